>>> rtl/ecsr_pkg.sv
// shared types and constants of the edge list to csr converter
// no dependencies; used by every module of the block
package ecsr_pkg;

    localparam int KIND_W      = 2;
    localparam int NODE_W      = 10;
    localparam int IDX_W       = 11;
    localparam int RATE_PORT_W = 64;
    localparam int STAT_W      = 2;
    localparam int KEY_W       = 2 * NODE_W;

    localparam int DEF_MAX_EDGES  = 1024;
    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_RATE_WIDTH = 64;

    localparam logic [IDX_W-1:0] NODE_COUNT_RST = 11'd1024;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_EDGE = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_NOT_CONV = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic resp;
        logic init;
        logic latch;
        logic scan;
        logic wr;
        logic i_next;
        logic rp_wr;
        logic pos_inc;
        logic node_inc;
        logic done;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic l_zero;
        logic i_last;
        logic i_kept;
        logic j_last;
        logic node_end;
        logic rp_match;
    } t_stat;

endpackage

>>> rtl/edge_list_to_csr_converter.sv
// top level of the edge list to csr converter
// depends on ecsr_pkg, ecsr_ctrl and ecsr_datapath
//
// usage: requests come in on i_in_valid / o_in_ready. a load request stores
// one edge in load order unless MAX_EDGES are stored; the load marked last
// starts conversion. row and edge read requests each give one result on
// o_out_valid / i_out_ready; loads and kind 3 give none. node_count is
// written by i_cfg_we / i_cfg_data and sampled when conversion starts;
// the user must write it only while the block is idle, which the block
// itself does not enforce. a read registers its table entry on acceptance
// and loads the output register in a later result step; no request is
// taken until that step is done. a waiting result does not block the next
// request; only the next read's result step waits until the output
// register is free. conversion is a rank sort over one read port of the
// edge store, followed by the row pointer build; no request is taken
// meanwhile. reset empties the edge list, clears the converted mark and
// sets node_count to 1024; the stores keep their contents.
module edge_list_to_csr_converter #(
    parameter int MAX_EDGES  = ecsr_pkg::DEF_MAX_EDGES,
    parameter int MAX_NODES  = ecsr_pkg::DEF_MAX_NODES,
    parameter int RATE_WIDTH = ecsr_pkg::DEF_RATE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ecsr_pkg::IDX_W-1:0]       i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [ecsr_pkg::KIND_W-1:0]      i_kind,
    input  logic [ecsr_pkg::NODE_W-1:0]      i_source_node,
    input  logic [ecsr_pkg::NODE_W-1:0]      i_dest_node,
    input  logic [ecsr_pkg::RATE_PORT_W-1:0] i_rate_bits,
    input  logic                             i_last_edge,
    input  logic [ecsr_pkg::IDX_W-1:0]       i_read_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [ecsr_pkg::IDX_W-1:0]       o_row_start,
    output logic [ecsr_pkg::NODE_W-1:0]      o_dest_out,
    output logic [ecsr_pkg::RATE_PORT_W-1:0] o_rate_out,
    output logic [ecsr_pkg::STAT_W-1:0]      o_status
);

    ecsr_pkg::t_cmd  cmd;
    ecsr_pkg::t_stat stat;

    ecsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_last_edge (i_last_edge),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ecsr_datapath #(
        .MAX_EDGES  (MAX_EDGES),
        .MAX_NODES  (MAX_NODES),
        .RATE_WIDTH (RATE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_source_node (i_source_node),
        .i_dest_node   (i_dest_node),
        .i_rate_bits   (i_rate_bits),
        .i_read_index  (i_read_index),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_row_start   (o_row_start),
        .o_dest_out    (o_dest_out),
        .o_rate_out    (o_rate_out),
        .o_status      (o_status)
    );

endmodule

>>> rtl/ecsr_datapath.sv
// datapath of the edge list to csr converter: edge stores, sorted stores,
// row pointer store, rank and row pointer counters, output register
// depends on ecsr_pkg
module ecsr_datapath #(
    parameter int MAX_EDGES  = ecsr_pkg::DEF_MAX_EDGES,
    parameter int MAX_NODES  = ecsr_pkg::DEF_MAX_NODES,
    parameter int RATE_WIDTH = ecsr_pkg::DEF_RATE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ecsr_pkg::t_cmd                   i_cmd,
    output ecsr_pkg::t_stat                  o_stat,
    input  logic                             i_cfg_we,
    input  logic [ecsr_pkg::IDX_W-1:0]       i_cfg_data,
    input  logic [ecsr_pkg::KIND_W-1:0]      i_kind,
    input  logic [ecsr_pkg::NODE_W-1:0]      i_source_node,
    input  logic [ecsr_pkg::NODE_W-1:0]      i_dest_node,
    input  logic [ecsr_pkg::RATE_PORT_W-1:0] i_rate_bits,
    input  logic [ecsr_pkg::IDX_W-1:0]       i_read_index,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [ecsr_pkg::IDX_W-1:0]       o_row_start,
    output logic [ecsr_pkg::NODE_W-1:0]      o_dest_out,
    output logic [ecsr_pkg::RATE_PORT_W-1:0] o_rate_out,
    output logic [ecsr_pkg::STAT_W-1:0]      o_status
);

    localparam int LW = $clog2(MAX_EDGES + 1);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int NW = $clog2(MAX_NODES + 1);
    localparam int NDW = ecsr_pkg::NODE_W;
    localparam int KW = ecsr_pkg::KEY_W;

    logic [NDW-1:0]        m_src [MAX_EDGES];
    logic [NDW-1:0]        m_dst [MAX_EDGES];
    logic [RATE_WIDTH-1:0] m_rate [MAX_EDGES];
    logic [NDW-1:0]        s_src [MAX_EDGES];
    logic [NDW-1:0]        s_dst [MAX_EDGES];
    logic [RATE_WIDTH-1:0] s_rate [MAX_EDGES];
    logic [LW-1:0]         m_ptr [MAX_NODES + 1];

    logic [ecsr_pkg::IDX_W-1:0] r_node_count;
    logic [LW-1:0]  r_loaded, r_conv_edges, r_n, r_i, r_j, r_jd, r_rank, r_pos;
    logic           r_conv, r_jv, r_ov;
    logic [NW-1:0]  r_conv_nodes, r_nodes, r_node;
    logic [NDW-1:0] r_ld_src, r_ld_dst, r_ss, r_rd_dst;
    logic [RATE_WIDTH-1:0] r_ld_rate, r_rate_i, r_rd_rate;
    logic [KW-1:0]  r_key_i;
    logic [LW-1:0]  r_rp;
    logic [ecsr_pkg::KIND_W-1:0] r_q_kind;
    logic [ecsr_pkg::IDX_W-1:0]  r_q_idx;
    logic [ecsr_pkg::IDX_W-1:0]  r_row;
    logic [NDW-1:0]              r_dout;
    logic [ecsr_pkg::RATE_PORT_W-1:0] r_rout;
    logic [ecsr_pkg::STAT_W-1:0] r_stat;

    logic [ecsr_pkg::IDX_W-1:0]       n_row;
    logic [NDW-1:0]                   n_dout;
    logic [ecsr_pkg::RATE_PORT_W-1:0] n_rout;
    logic [ecsr_pkg::STAT_W-1:0]      n_stat;

    logic [LW-1:0] eff_cnt;
    logic [EW-1:0] ld_addr;
    logic [KW-1:0] key_j;
    logic          keep_j, less_j;
    logic [NW-1:0] eff_nodes;

    always_comb begin
        eff_cnt   = r_conv ? '0 : r_loaded;
        ld_addr   = i_cmd.scan ? EW'(r_j) : EW'(r_i);
        key_j     = {r_ld_src, r_ld_dst};
        keep_j    = 32'(r_ld_src) < 32'(r_nodes);
        less_j    = (key_j < r_key_i) || ((key_j == r_key_i) && (r_jd < r_i));
        eff_nodes = (32'(r_node_count) < 32'(MAX_NODES)) ? NW'(r_node_count)
                                                         : NW'(MAX_NODES);
        o_stat.out_free = !r_ov || i_out_ready;
        o_stat.l_zero   = (r_loaded == '0);
        o_stat.i_last   = (r_i == r_loaded - LW'(1));
        o_stat.i_kept   = keep_j;
        o_stat.j_last   = (r_j == r_loaded - LW'(1));
        o_stat.node_end = (r_node == r_nodes);
        o_stat.rp_match = (r_pos < r_n) && (32'(r_ss) == 32'(r_node));
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(eff_cnt) < 32'(MAX_EDGES))) begin
            m_src[EW'(eff_cnt)]  <= i_source_node;
            m_dst[EW'(eff_cnt)]  <= i_dest_node;
            m_rate[EW'(eff_cnt)] <= RATE_WIDTH'(i_rate_bits);
        end
        r_ld_src  <= m_src[ld_addr];
        r_ld_dst  <= m_dst[ld_addr];
        r_ld_rate <= m_rate[ld_addr];
        if (i_cmd.wr) begin
            s_src[EW'(r_rank)]  <= r_key_i[KW-1:NDW];
            s_dst[EW'(r_rank)]  <= r_key_i[NDW-1:0];
            s_rate[EW'(r_rank)] <= r_rate_i;
        end
        r_ss <= s_src[EW'(r_pos)];
        if (i_cmd.rp_wr) begin
            m_ptr[r_node] <= r_pos;
        end
        if (i_cmd.rd_issue) begin
            r_rp      <= m_ptr[NW'(i_read_index)];
            r_rd_dst  <= s_dst[EW'(i_read_index)];
            r_rd_rate <= s_rate[EW'(i_read_index)];
            r_q_kind  <= i_kind;
            r_q_idx   <= i_read_index;
        end
    end

    // sort and row pointer datapath
    always_ff @(posedge i_clk) begin
        r_jv <= i_cmd.scan;
        r_jd <= r_j;
        if (i_cmd.scan) begin
            r_j <= r_j + LW'(1);
        end
        if (i_cmd.latch) begin
            r_key_i  <= {r_ld_src, r_ld_dst};
            r_rate_i <= r_ld_rate;
            r_rank   <= '0;
            r_j      <= '0;
        end else if (r_jv && keep_j && less_j) begin
            r_rank <= r_rank + LW'(1);
        end
        if (i_cmd.init) begin
            r_nodes <= eff_nodes;
            r_i     <= '0;
            r_n     <= '0;
            r_node  <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.i_next) begin
                r_i <= r_i + LW'(1);
            end
            if (i_cmd.wr) begin
                r_n <= r_n + LW'(1);
            end
            if (i_cmd.pos_inc) begin
                r_pos <= r_pos + LW'(1);
            end
            if (i_cmd.node_inc) begin
                r_node <= r_node + NW'(1);
            end
        end
        if (i_cmd.done) begin
            r_conv_nodes <= r_nodes;
            r_conv_edges <= r_n;
        end
    end

    // control state of the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ecsr_pkg::NODE_COUNT_RST;
            r_loaded     <= '0;
            r_conv       <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_conv   <= 1'b0;
                r_loaded <= (32'(eff_cnt) < 32'(MAX_EDGES)) ? eff_cnt + LW'(1) : eff_cnt;
            end else if (i_cmd.done) begin
                r_conv <= 1'b1;
            end
            if (i_cmd.resp) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // next result
    always_comb begin
        n_row  = '0;
        n_dout = '0;
        n_rout = '0;
        n_stat = ecsr_pkg::ST_OK;
        if (!r_conv) begin
            n_stat = ecsr_pkg::ST_NOT_CONV;
        end else if (r_q_kind == ecsr_pkg::KIND_ROW) begin
            if (32'(r_q_idx) <= 32'(r_conv_nodes)) begin
                n_row = ecsr_pkg::IDX_W'(r_rp);
            end else begin
                n_stat = ecsr_pkg::ST_RANGE;
            end
        end else begin
            if (32'(r_q_idx) < 32'(r_conv_edges)) begin
                n_dout = r_rd_dst;
                n_rout = ecsr_pkg::RATE_PORT_W'(r_rd_rate);
            end else begin
                n_stat = ecsr_pkg::ST_RANGE;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_row  <= n_row;
            r_dout <= n_dout;
            r_rout <= n_rout;
            r_stat <= n_stat;
        end
    end

    assign o_out_valid = r_ov;
    assign o_row_start = r_row;
    assign o_dest_out  = r_dout;
    assign o_rate_out  = r_rout;
    assign o_status    = r_stat;

endmodule

>>> rtl/ecsr_ctrl.sv
// controller of the edge list to csr converter: request handling,
// rank sort sequencing and row pointer build
// depends on ecsr_pkg
module ecsr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ecsr_pkg::KIND_W-1:0] i_kind,
    input  logic                        i_last_edge,
    input  ecsr_pkg::t_stat             i_stat,
    output ecsr_pkg::t_cmd              o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_RESP, S_INIT, S_ORD, S_OLAT, S_SCAN, S_SEND, S_WR,
        S_RPWR, S_RPRD, S_RPCHK
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        accept     = i_in_valid && o_in_ready;
        o_cmd      = '0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        ecsr_pkg::KIND_LOAD: begin
                            o_cmd.load = 1'b1;
                            if (i_last_edge) begin
                                n_state = S_INIT;
                            end
                        end
                        ecsr_pkg::KIND_ROW, ecsr_pkg::KIND_EDGE: begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.resp = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = i_stat.l_zero ? S_RPWR : S_ORD;
            end
            S_ORD: n_state = S_OLAT;
            S_OLAT: begin
                if (i_stat.i_kept) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SCAN;
                end else begin
                    o_cmd.i_next = 1'b1;
                    n_state      = i_stat.i_last ? S_RPWR : S_ORD;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.j_last) begin
                    n_state = S_SEND;
                end
            end
            // last compare result lands in this cycle
            S_SEND: n_state = S_WR;
            S_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.i_next = 1'b1;
                n_state      = i_stat.i_last ? S_RPWR : S_ORD;
            end
            S_RPWR: begin
                o_cmd.rp_wr = 1'b1;
                if (i_stat.node_end) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_RPRD;
                end
            end
            S_RPRD: n_state = S_RPCHK;
            S_RPCHK: begin
                if (i_stat.rp_match) begin
                    o_cmd.pos_inc = 1'b1;
                    n_state       = S_RPRD;
                end else begin
                    o_cmd.node_inc = 1'b1;
                    n_state        = S_RPWR;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/ecsr_checker.sv
// port level checks of the edge list to csr converter, bound to the top level
// depends on ecsr_pkg
module ecsr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic [ecsr_pkg::KIND_W-1:0]      i_kind,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic [ecsr_pkg::IDX_W-1:0]       o_row_start,
    input logic [ecsr_pkg::NODE_W-1:0]      o_dest_out,
    input logic [ecsr_pkg::RATE_PORT_W-1:0] o_rate_out,
    input logic [ecsr_pkg::STAT_W-1:0]      o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_row_start) && $stable(o_dest_out) && $stable(o_rate_out))
        else $error("result changed while stalled");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ecsr_pkg::ST_OK |->
        o_row_start == '0 && o_dest_out == '0 && o_rate_out == '0)
        else $error("error result with nonzero fields");

    // a read request keeps the block busy the next cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        && (i_kind == ecsr_pkg::KIND_ROW || i_kind == ecsr_pkg::KIND_EDGE)
        |=> !o_in_ready)
        else $error("ready right after a read request");

    // a row result never names both a row and an edge
    a_one_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_row_start != '0 |-> o_dest_out == '0 && o_rate_out == '0)
        else $error("row and edge fields both set");

endmodule

bind edge_list_to_csr_converter ecsr_checker u_ecsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_kind      (i_kind),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_row_start (o_row_start),
    .o_dest_out  (o_dest_out),
    .o_rate_out  (o_rate_out),
    .o_status    (o_status)
);

>>> tb/tb.sv
// testbench of edge_list_to_csr_converter: random and directed edge lists and reads,
// checked against an in-bench predictor of the sorted csr tables
// depends on ecsr_pkg and the rtl of the converter
module tb;
    import ecsr_pkg::*;

    typedef struct {
        t_kind            kind;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [63:0]      rate;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_req;

    typedef struct {
        logic [IDX_W-1:0]  row;
        logic [NODE_W-1:0] dst;
        logic [63:0]       rate;
        t_status           st;
    } t_read_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [IDX_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [KIND_W-1:0] i_kind = '0;
    logic [NODE_W-1:0] i_source_node = '0;
    logic [NODE_W-1:0] i_dest_node = '0;
    logic [63:0] i_rate_bits = '0;
    logic i_last_edge = 1'b0;
    logic [IDX_W-1:0] i_read_index = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [IDX_W-1:0] o_row_start;
    logic [NODE_W-1:0] o_dest_out;
    logic [63:0] o_rate_out;
    logic [STAT_W-1:0] o_status;

    edge_list_to_csr_converter DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_kind(i_kind), .i_source_node(i_source_node), .i_dest_node(i_dest_node),
        .i_rate_bits(i_rate_bits), .i_last_edge(i_last_edge),
        .i_read_index(i_read_index),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_row_start(o_row_start), .o_dest_out(o_dest_out),
        .o_rate_out(o_rate_out), .o_status(o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req         pending_reqs[$];
    t_read_result expected_reads[$];
    int  errors = 0;
    int  hold_cycles = 0;
    bit  no_idle = 0;
    int  items_queued = 0;

    // predictor state
    logic [NODE_W-1:0] csr_src[DEF_MAX_EDGES];
    logic [NODE_W-1:0] csr_dst[DEF_MAX_EDGES];
    logic [63:0]       csr_rate[DEF_MAX_EDGES];
    logic [IDX_W-1:0]  csr_rowp[DEF_MAX_NODES+1];
    int  csr_loaded = 0;
    bit  csr_converted = 0;
    int  cfg_nodes = 1024;
    int  csr_rows = 0;
    int  csr_edges = 0;

    function automatic void csr_convert();
        logic [NODE_W-1:0] ks[$], kd[$];
        logic [63:0] kr[$];
        int rows, n, pos, j;
        logic [NODE_W-1:0] ts, td;
        logic [63:0] tr;
        rows = (cfg_nodes < DEF_MAX_NODES) ? cfg_nodes : DEF_MAX_NODES;
        for (int i = 0; i < csr_loaded; i++) begin
            if (csr_src[i] < rows) begin
                ks.push_back(csr_src[i]);
                kd.push_back(csr_dst[i]);
                kr.push_back(csr_rate[i]);
            end
        end
        n = ks.size();
        // stable insertion sort on {source, destination}
        for (int i = 1; i < n; i++) begin
            ts = ks[i]; td = kd[i]; tr = kr[i];
            j = i - 1;
            while (j >= 0 && {ks[j], kd[j]} > {ts, td}) begin
                ks[j+1] = ks[j]; kd[j+1] = kd[j]; kr[j+1] = kr[j];
                j--;
            end
            ks[j+1] = ts; kd[j+1] = td; kr[j+1] = tr;
        end
        for (int i = 0; i < n; i++) begin
            csr_src[i] = ks[i]; csr_dst[i] = kd[i]; csr_rate[i] = kr[i];
        end
        pos = 0;
        for (int r = 0; r < rows; r++) begin
            csr_rowp[r] = IDX_W'(pos);
            while (pos < n && csr_src[pos] == r) pos++;
        end
        csr_rowp[rows] = IDX_W'(pos);
        csr_rows = rows;
        csr_edges = n;
        csr_converted = 1;
    endfunction

    function automatic void csr_accept(t_req r);
        t_read_result e;
        if (r.kind == KIND_LOAD) begin
            if (csr_converted) begin
                csr_converted = 0;
                csr_loaded = 0;
            end
            if (csr_loaded < DEF_MAX_EDGES) begin
                csr_src[csr_loaded] = r.src;
                csr_dst[csr_loaded] = r.dst;
                csr_rate[csr_loaded] = r.rate;
                csr_loaded++;
            end
            if (r.last) csr_convert();
            return;
        end
        if (r.kind == KIND_NONE) return;
        e.row = '0; e.dst = '0; e.rate = '0; e.st = ST_OK;
        if (!csr_converted) e.st = ST_NOT_CONV;
        else if (r.kind == KIND_ROW) begin
            if (r.idx <= csr_rows) e.row = csr_rowp[r.idx];
            else e.st = ST_RANGE;
        end else begin
            if (r.idx < csr_edges) begin
                e.dst = csr_dst[r.idx];
                e.rate = csr_rate[r.idx];
            end else e.st = ST_RANGE;
        end
        expected_reads.push_back(e);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    t_req cur;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) csr_accept(cur);
            if (!i_in_valid || o_in_ready) begin
                if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 31)) begin
                    cur = pending_reqs.pop_front();
                    i_in_valid    <= 1'b1;
                    i_kind        <= cur.kind;
                    i_source_node <= cur.src;
                    i_dest_node   <= cur.dst;
                    i_rate_bits   <= cur.rate;
                    i_last_edge   <= cur.last;
                    i_read_index  <= cur.idx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result side: stall control and checking
    always @(posedge i_clk) begin
        t_read_result e;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_reads.size() == 0) begin
                    report_mismatch("unexpected result", 64'(o_status), 64'(0));
                end else begin
                    e = expected_reads.pop_front();
                    if (o_status !== e.st)
                        report_mismatch("status", 64'(o_status), 64'(e.st));
                    if (o_row_start !== e.row)
                        report_mismatch("row_start", 64'(o_row_start), 64'(e.row));
                    if (o_dest_out !== e.dst)
                        report_mismatch("dest_out", 64'(o_dest_out), 64'(e.dst));
                    if (o_rate_out !== e.rate) report_mismatch("rate_out", o_rate_out, e.rate);
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= no_idle || ($urandom_range(99) >= 31);
            end
        end
    end

    function automatic void push_req(t_kind k, int s, int d, logic [63:0] rt, bit l, int ix);
        t_req r;
        r.kind = k; r.src = NODE_W'(s); r.dst = NODE_W'(d); r.rate = rt; r.last = l;
        r.idx = IDX_W'(ix);
        pending_reqs.push_back(r);
        items_queued++;
    endfunction

    function automatic logic [63:0] rand_rate();
        return {$urandom, $urandom};
    endfunction

    // also waits out a conversion still running in the block
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_reads.size() != 0
               || !o_in_ready);
        repeat (5) @(negedge i_clk);
    endtask

    task automatic write_node_count(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= IDX_W'(v);
        cfg_nodes = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one list of edges, with stray kind 3 and read requests mixed in, followed by reads of the result
    task automatic edge_list_phase(int len, int src_hi, int dst_hi, int nreads);
        int rows, ix;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 4) push_req(KIND_NONE, $urandom, $urandom, rand_rate(), 1, 0);
            if (i > 0 && $urandom_range(99) < 3)
                push_req(t_kind'($urandom_range(1, 2)), 0, 0, 0, $urandom_range(1), 0);
            push_req(KIND_LOAD, $urandom_range(src_hi), $urandom_range(dst_hi), rand_rate(),
                     i == len - 1, $urandom_range(1024));
        end
        rows = (cfg_nodes < DEF_MAX_NODES) ? cfg_nodes : DEF_MAX_NODES;
        for (int i = 0; i < nreads; i++) begin
            if ($urandom_range(1)) begin
                ix = ($urandom_range(9) == 0) ? $urandom_range(1024) :
                     $urandom_range((rows + 2 > 1024) ? 1024 : rows + 2);
                push_req(KIND_ROW, $urandom, $urandom, rand_rate(), $urandom_range(1), ix);
            end else begin
                ix = ($urandom_range(9) == 0) ? $urandom_range(1024) : $urandom_range(len + 2);
                push_req(KIND_EDGE, $urandom, $urandom, rand_rate(), $urandom_range(1), ix);
            end
        end
    endtask

    initial begin
        int v, len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads before conversion, extremes, duplicates, kind 3
        push_req(KIND_ROW, 0, 0, 0, 0, 0);
        push_req(KIND_EDGE, 0, 0, 0, 1, 0);
        push_req(KIND_NONE, 1023, 1023, '1, 1, 1024);
        push_req(KIND_LOAD, 1023, 0, '1, 0, 0);
        push_req(KIND_LOAD, 0, 1023, 64'd0, 0, 0);
        push_req(KIND_LOAD, 5, 7, 64'h1111, 0, 0);
        push_req(KIND_LOAD, 5, 7, 64'h2222, 0, 0);
        push_req(KIND_LOAD, 5, 3, 64'h3333, 1, 1024);
        push_req(KIND_ROW, 0, 0, 0, 0, 0);
        push_req(KIND_ROW, 0, 0, 0, 0, 5);
        push_req(KIND_ROW, 0, 0, 0, 0, 1023);
        push_req(KIND_ROW, 0, 0, 0, 1, 1024);
        for (int i = 0; i < 6; i++) push_req(KIND_EDGE, 0, 0, 0, i & 1, i);
        push_req(KIND_EDGE, 0, 0, 0, 0, 1024);
        push_req(KIND_LOAD, 2, 2, 64'h5, 0, 0);
        push_req(KIND_ROW, 0, 0, 0, 0, 0);
        push_req(KIND_LOAD, 1, 1, 64'h6, 1, 0);
        push_req(KIND_EDGE, 0, 0, 0, 0, 1);
        wait_drained();

        // zero, saturated and single-row node counts
        for (int k = 0; k < 3; k++) begin
            v = (k == 0) ? 0 : (k == 1) ? 2047 : 1;
            write_node_count(v);
            edge_list_phase(12, 3, 1023, 10);
            push_req(KIND_ROW, 0, 0, 0, 0, 0);
            wait_drained();
        end

        // more edges than capacity; with one row the sort stays short
        write_node_count(1);
        for (int i = 0; i < DEF_MAX_EDGES + 6; i++)
            push_req(KIND_LOAD, (i % 97 == 0) ? 0 : $urandom_range(1, 1023), $urandom,
                     rand_rate(), i == DEF_MAX_EDGES + 5, 0);
        for (int i = 0; i < 16; i++) push_req(KIND_EDGE, 0, 0, 0, 0, i);
        push_req(KIND_ROW, 0, 0, 0, 0, 1);
        push_req(KIND_ROW, 0, 0, 0, 0, 2);
        wait_drained();

        write_node_count(1024);
        edge_list_phase(20, 1023, 1023, 30);
        wait_drained();

        // receiver holds off while requests keep coming
        write_node_count(8);
        edge_list_phase(10, 9, 3, 0);
        wait_drained();
        hold_cycles = 400;
        edge_list_phase(0, 0, 0, 60);
        wait_drained();

        // stretch without any idling
        no_idle = 1;
        edge_list_phase(16, 9, 5, 40);
        wait_drained();
        no_idle = 0;

        while (items_queued < 1950) begin
            case ($urandom_range(7))
                0: v = 1024;
                1: v = $urandom_range(1, 1024);
                2: v = 2047;
                default: v = $urandom_range(1, 40);
            endcase
            write_node_count(v);
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 24);
            edge_list_phase(len, ($urandom_range(3) == 0) ? 1023 : ((v + 3 > 1023) ? 1023 : v + 3),
                            ($urandom_range(1)) ? 1023 : 3, $urandom_range(10, 50));
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ecsr_pkg.sv
rtl/ecsr_datapath.sv
rtl/ecsr_ctrl.sv
rtl/edge_list_to_csr_converter.sv
rtl/ecsr_checker.sv
tb/tb.sv
